>>> design/per_path_token_bucket_policer_core_macros.svh
// assertion macros for the per-path token bucket policer
// used by the checker module; no other dependencies
`ifndef PER_PATH_TOKEN_BUCKET_POLICER_CORE_MACROS_SVH
`define PER_PATH_TOKEN_BUCKET_POLICER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PPOL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("policer assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PPOL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("policer assertion failed");

`endif

>>> design/ppol_pkg.sv
// shared types and constants of the per-path token bucket policer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ppol_pkg;

	localparam int PATH_ID_W     = 10;
	localparam int WORD_W        = 64;
	localparam int COST_W        = 16;
	localparam int MUL_W         = 32;
	localparam int ELAPSED_SHIFT = 10;
	localparam int RATE_SHIFT    = 22;

	localparam logic CMD_POLICE = 1'b0;
	localparam logic CMD_WRITE  = 1'b1;

	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] rate;
		logic [WORD_W-1:0] limit;
		logic [WORD_W-1:0] tokens;
		logic [WORD_W-1:0] last;
	} entry_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_LOOKUP,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_LEVEL,
		ST_DECIDE
	} state_t;

endpackage

`default_nettype wire

>>> design/ppol_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ppol_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/ppol_mul.sv
// shared 32x32 multiplier with registered product
// depends on ppol_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppol_mul (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [ppol_pkg::MUL_W-1:0]   a,
	input  wire logic [ppol_pkg::MUL_W-1:0]   b,
	output      logic [2*ppol_pkg::MUL_W-1:0] p
);

	import ppol_pkg::*;

	logic [2*MUL_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

	assign p = p_q;

endmodule

`default_nettype wire

>>> design/per_path_token_bucket_policer_core.sv
// per-path token bucket policer: entry table in ram, refill product on one shared multiplier.
// a write or an out-of-table path is answered from the dispatch state, an invalid entry or
// zero rate from the lookup state; a policed packet goes through ram read, three partial products
// on the 32x32 multiplier, add/clamp and decide. one item at a time; out_stall can hold the result.
// reset: asynchronous; afterwards a clearing pass marks every entry invalid
// while in_stall stays high.
`timescale 1ns / 1ps
`default_nettype none

module per_path_token_bucket_policer_core #(
	parameter int PATHS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic        cmd,
	input  wire logic [9:0]  path_id,
	input  wire logic [63:0] now_ns,
	input  wire logic [15:0] pkt_cost,
	input  wire logic        entry_valid,
	input  wire logic [63:0] entry_rate,
	input  wire logic [63:0] entry_burst,
	input  wire logic [63:0] entry_tokens,
	input  wire logic [63:0] entry_time,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic        pass,
	output      logic [63:0] tokens_left
);

	import ppol_pkg::*;

	localparam int AW     = $clog2(PATHS);
	localparam int XW     = (AW > PATH_ID_W) ? AW : PATH_ID_W;
	localparam int ENT_W  = $bits(entry_t);
	localparam logic [AW-1:0] CLR_LAST = AW'(PATHS - 1);

	state_t state_q, state_d;

	// captured transaction
	logic                 cmd_q;
	logic [PATH_ID_W-1:0] path_q;
	logic [WORD_W-1:0]    now_q;
	logic [COST_W-1:0]    cost_q;
	logic                 ev_q;
	logic [WORD_W-1:0]    erate_q, eburst_q, etok_q, etime_q;

	logic [AW-1:0]        clr_q;
	entry_t               ent_q;
	logic [WORD_W-ELAPSED_SHIFT-1:0] opa_q;
	logic [WORD_W-1:0]    refill_q;
	logic [WORD_W-1:0]    level_q;

	logic                 out_valid_q, pass_q;
	logic [WORD_W-1:0]    tokens_q;

	// ram and multiplier hookup
	logic                 ram_we, ram_re;
	logic [AW-1:0]        ram_waddr;
	entry_t               ram_wdata, ram_rdata;
	logic [ENT_W-1:0]     ram_rdata_raw;
	logic                 mul_en;
	logic [MUL_W-1:0]     mul_a, mul_b;
	logic [2*MUL_W-1:0]   mul_p;

	logic                 res_load, res_pass;
	logic [WORD_W-1:0]    res_tokens;

	logic [XW-1:0]        path_ext;
	logic [AW-1:0]        idx;
	logic                 in_range, out_free, special;
	logic [WORD_W-1:0]    diff, sum, cost_ext, next_tokens;
	logic [WORD_W-RATE_SHIFT-1:0] opb;
	logic                 fits;

	assign path_ext = XW'(path_q);
	assign idx      = path_ext[AW-1:0];
	assign in_range = ({{(32-PATH_ID_W){1'b0}}, path_q} < 32'(PATHS));
	assign out_free = !out_valid_q || !out_stall;
	assign ram_rdata = entry_t'(ram_rdata_raw);
	assign special  = !ram_rdata.valid || (ram_rdata.rate == '0);

	// elapsed time, negative as signed reads as zero
	assign diff     = now_q - ram_rdata.last;
	assign opb      = ent_q.rate[WORD_W-1:RATE_SHIFT];
	assign sum      = ent_q.tokens + refill_q;
	assign cost_ext = {{(WORD_W-COST_W){1'b0}}, cost_q};
	assign fits     = (level_q >= cost_ext);
	assign next_tokens = fits ? (level_q - cost_ext) : level_q;

	ppol_ram #(
		.WIDTH(ENT_W),
		.DEPTH(PATHS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(idx),
		.rdata(ram_rdata_raw)
	);

	ppol_mul u_mul (
		.clk(clk),
		.en (mul_en),
		.a  (mul_a),
		.b  (mul_b),
		.p  (mul_p)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (!in_range || cmd_q == CMD_WRITE) begin
					if (out_free) state_d = ST_IDLE;
				end else begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (special) begin
					if (out_free) state_d = ST_IDLE;
				end else begin
					state_d = ST_MUL0;
				end
			end
			ST_MUL0:  state_d = ST_MUL1;
			ST_MUL1:  state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_MUL3;
			ST_MUL3:  state_d = ST_LEVEL;
			ST_LEVEL: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_waddr  = idx;
		ram_wdata  = '{valid: ev_q, rate: erate_q, limit: eburst_q, tokens: etok_q,
			last: etime_q};
		mul_en     = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		res_load   = 1'b0;
		res_pass   = 1'b0;
		res_tokens = '0;
		unique case (state_q) inside
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_DISPATCH: begin
				if (!in_range) begin
					res_load = out_free;
					res_pass = (cmd_q == CMD_POLICE);
				end else if (cmd_q == CMD_WRITE) begin
					ram_we     = out_free;
					res_load   = out_free;
					res_tokens = ev_q ? etok_q : '0;
				end else begin
					ram_re = 1'b1;
				end
			end
			ST_LOOKUP: begin
				if (special) begin
					res_load   = out_free;
					res_pass   = 1'b1;
					res_tokens = ram_rdata.valid ? ram_rdata.tokens : '0;
				end
			end
			// partial products: a0*b0, a0*b1, a1*b0; a1*b1 lies above bit 63
			ST_MUL0: begin
				mul_en = 1'b1;
				mul_a  = opa_q[MUL_W-1:0];
				mul_b  = opb[MUL_W-1:0];
			end
			ST_MUL1: begin
				mul_en = 1'b1;
				mul_a  = opa_q[MUL_W-1:0];
				mul_b  = MUL_W'(opb[WORD_W-RATE_SHIFT-1:MUL_W]);
			end
			ST_MUL2: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(opa_q[WORD_W-ELAPSED_SHIFT-1:MUL_W]);
				mul_b  = opb[MUL_W-1:0];
			end
			ST_DECIDE: begin
				ram_we     = out_free;
				ram_wdata  = '{valid: 1'b1, rate: ent_q.rate, limit: ent_q.limit,
					tokens: next_tokens, last: now_q};
				res_load   = out_free;
				res_pass   = fits;
				res_tokens = next_tokens;
			end
			ST_IDLE, ST_MUL3, ST_LEVEL: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (res_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q    <= cmd;
			path_q   <= path_id;
			now_q    <= now_ns;
			cost_q   <= pkt_cost;
			ev_q     <= entry_valid;
			erate_q  <= entry_rate;
			eburst_q <= entry_burst;
			etok_q   <= entry_tokens;
			etime_q  <= entry_time;
		end
		if (state_q == ST_LOOKUP) begin
			ent_q <= ram_rdata;
			opa_q <= diff[WORD_W-1] ? '0 : diff[WORD_W-1:ELAPSED_SHIFT];
		end
		case (state_q) inside
			ST_MUL1: refill_q <= mul_p;
			ST_MUL2, ST_MUL3: begin
				refill_q[WORD_W-1:MUL_W] <= refill_q[WORD_W-1:MUL_W] + mul_p[MUL_W-1:0];
			end
			default: begin
			end
		endcase
		if (state_q == ST_LEVEL) begin
			level_q <= (sum > ent_q.limit) ? ent_q.limit : sum;
		end
		if (res_load) begin
			pass_q   <= res_pass;
			tokens_q <= res_tokens;
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign pass        = pass_q;
	assign tokens_left = tokens_q;

endmodule

`default_nettype wire

>>> design/ppol_checker.sv
// port-level checker for the per-path token bucket policer, bound to the top level
// depends on per_path_token_bucket_policer_core_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "per_path_token_bucket_policer_core_macros.svh"

module ppol_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        pass,
	input wire logic [63:0] tokens_left
);

	// one transaction at a time: busy right after an accept
	`PPOL_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// a new result only comes out of a cycle in which the block was working
	`PPOL_ASSERT_IMPL(a_result_from_busy, clk, arst_n, $rose(out_valid), $past(in_stall))

	`PPOL_ASSERT_NEXT(a_out_valid_holds, clk, arst_n, out_valid && out_stall, out_valid)

	`PPOL_ASSERT_NEXT(a_out_payload_holds, clk, arst_n, out_valid && out_stall,
		$stable(pass) && $stable(tokens_left))

endmodule

bind per_path_token_bucket_policer_core ppol_checker u_ppol_checker (.*);

`default_nettype wire
